>>> sv/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int COORD_W    = 16;
   localparam int EDGE_W     = COORD_W + 2;
   localparam int AREA_W     = 2 * COORD_W;
   localparam int SUM_W      = AREA_W + 1;
   localparam int THR_W      = 16;
   localparam int PROD_W     = SUM_W + THR_W;
   localparam int IDX_W      = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

   // register index, taken from the word address
   typedef enum logic [0:0] {
      REG_IOU_THRESHOLD = 1'b0,
      REG_UNMAPPED      = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [COORD_W-1:0]        w;
      logic [COORD_W-1:0]        h;
   } box_type;

   // item travelling along the row of cells
   typedef struct packed {
      logic              tok;
      box_type           box;
      logic [AREA_W-1:0] area;
   } fwd_type;

   // suppression verdict trailing the item
   typedef struct packed {
      logic done;
      logic hit;
   } verdict_type;

   typedef struct packed {
      logic             keep;
      logic             overflow;
      logic [IDX_W-1:0] box_index;
   } result_type;

endpackage

>>> sv/gbn_cell.sv
// ----------------------------------------------------------------------------
// gbn_cell
// One kept box of the row: compares the passing box with its own entry over
// a short pipeline and ORs its verdict into the trailing suppress flag.
// ----------------------------------------------------------------------------
module gbn_cell #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gbn_pkg::fwd_type                  fwd_in,
   output gbn_pkg::fwd_type                  fwd_out,
   input  gbn_pkg::verdict_type              vrd_in,
   output gbn_pkg::verdict_type              vrd_out,
   input  logic [CNT_W-1:0]                  kept_count,
   input  logic [gbn_pkg::THR_W-1:0]         threshold,
   input  logic                              wr_en,
   input  logic [CNT_W-1:0]                  wr_idx,
   input  gbn_pkg::box_type                  wr_box,
   input  logic [gbn_pkg::AREA_W-1:0]        wr_area
);
   import gbn_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   box_type             kept_box_ff;
   logic [AREA_W-1:0]   kept_area_ff;
   fwd_type             fwd_ff;

   logic                act1_ff, act2_ff, act3_ff;
   logic                tok1_ff, tok2_ff, tok3_ff;
   logic [COORD_W-1:0]  ov_x_ff, ov_y_ff;
   logic [AREA_W-1:0]   inter_ff, inter3_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [PROD_W-1:0]   prod_ff;
   verdict_type         vrd_ff;

   logic                act1_in;
   logic [COORD_W-1:0]  ov_x_in, ov_y_in;
   logic [AREA_W-1:0]   inter_in;
   logic [SUM_W-1:0]    sum_in, union_val;
   logic [PROD_W-1:0]   prod_in;
   logic                hit;
   verdict_type         vrd_in_next;

   logic signed [EDGE_W-1:0] xn, xk, rn, rk, yn, yk, bn, bk;
   logic signed [EDGE_W-1:0] left, right, top_e, bottom, dx, dy;

   always_comb begin
      xn = {{2{fwd_in.box.x[COORD_W-1]}}, fwd_in.box.x};
      xk = {{2{kept_box_ff.x[COORD_W-1]}}, kept_box_ff.x};
      yn = {{2{fwd_in.box.y[COORD_W-1]}}, fwd_in.box.y};
      yk = {{2{kept_box_ff.y[COORD_W-1]}}, kept_box_ff.y};
      rn = xn + $signed({2'b00, fwd_in.box.w});
      rk = xk + $signed({2'b00, kept_box_ff.w});
      bn = yn + $signed({2'b00, fwd_in.box.h});
      bk = yk + $signed({2'b00, kept_box_ff.h});
      left   = (xn > xk) ? xn : xk;
      top_e  = (yn > yk) ? yn : yk;
      right  = (rn < rk) ? rn : rk;
      bottom = (bn < bk) ? bn : bk;
      dx = right - left;
      dy = bottom - top_e;
      // a positive overlap never exceeds the narrower box, so 16 bits hold it
      ov_x_in = (dx > 0) ? dx[COORD_W-1:0] : '0;
      ov_y_in = (dy > 0) ? dy[COORD_W-1:0] : '0;
      act1_in = fwd_in.tok && (MY_INDEX < kept_count);

      inter_in  = AREA_W'(ov_x_ff) * AREA_W'(ov_y_ff);
      sum_in    = SUM_W'(fwd_ff.area) + SUM_W'(kept_area_ff);
      union_val = sum_ff - SUM_W'(inter_ff);
      prod_in   = PROD_W'(threshold) * PROD_W'(union_val);

      hit = act3_ff && ({1'b0, inter3_ff, 16'h0000} > prod_ff);
      vrd_in_next.done = tok3_ff;
      vrd_in_next.hit  = vrd_in.hit | hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff.tok <= 1'b0;
         act1_ff    <= 1'b0;
         act2_ff    <= 1'b0;
         act3_ff    <= 1'b0;
         tok1_ff    <= 1'b0;
         tok2_ff    <= 1'b0;
         tok3_ff    <= 1'b0;
         vrd_ff     <= '0;
      end else begin
         fwd_ff.tok <= fwd_in.tok;
         act1_ff    <= act1_in;
         act2_ff    <= act1_ff;
         act3_ff    <= act2_ff;
         tok1_ff    <= fwd_in.tok;
         tok2_ff    <= tok1_ff;
         tok3_ff    <= tok2_ff;
         vrd_ff     <= vrd_in_next;
      end
      fwd_ff.box  <= fwd_in.box;
      fwd_ff.area <= fwd_in.area;
   end

   always_ff @(posedge clock) begin
      ov_x_ff     <= ov_x_in;
      ov_y_ff     <= ov_y_in;
      inter_ff    <= inter_in;
      sum_ff      <= sum_in;
      inter3_ff   <= inter_ff;
      prod_ff     <= prod_in;
      if (wr_en && (wr_idx == MY_INDEX)) begin
         kept_box_ff  <= wr_box;
         kept_area_ff <= wr_area;
      end
   end

   assign fwd_out = fwd_ff;
   assign vrd_out = vrd_ff;

endmodule

>>> sv/greedy_box_nms_core.sv
// ----------------------------------------------------------------------------
// greedy_box_nms_core
// Greedy IoU suppression of score-sorted boxes against a row of kept boxes.
// ----------------------------------------------------------------------------
// Boxes come in on the req_ stream one item each, sorted by falling score.
// tuser carries first_of_set, which empties the kept list and restarts the
// box index. Each box yields one rsp_ item: keep, overflow and its index.
// The box walks a row of MAX_KEPT cells, one cell per cycle; every cell
// holds one kept box and runs its overlap test in a pipeline of its own, so a
// result is ready for the output register once the verdict leaves the last cell.
// One box is in the row at a time: the next one is taken only after the
// result of the previous one has entered the output register.
// If the receiver stalls, the finished result waits in the output register
// and the next box is still accepted and processed; its result then waits in
// a holding register, and no further box is taken until that one moves on.
// The threshold is written through the csr_ port at byte address 0.
// Reset empties the kept list, zeroes the box index, restores the threshold
// to 29491 and drops any item in flight.
// ----------------------------------------------------------------------------
module greedy_box_nms_core #(
   parameter int MAX_KEPT  = 64,
   parameter int MAX_BOXES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: box_x, box_y, box_width, box_height (from bit 0 up)
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [63:0]                       req_tdata,
   // req_tuser: first_of_set
   input  logic                              req_tuser,
   // rsp_tdata: box_index, zero padding (from bit 0 up)
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,
   // rsp_tuser: keep, overflow (from bit 0 up)
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gbn_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gbn_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import gbn_pkg::*;

   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam int LIMIT = (MAX_BOXES - 1 > 4095) ? 4095 : MAX_BOXES - 1;
   localparam logic [IDX_W-1:0] POS_LIMIT = IDX_W'(LIMIT);
   localparam logic [CNT_W-1:0] KEPT_FULL = CNT_W'(MAX_KEPT);

   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic              tok_ff, tok_in;
   logic              busy_ff, busy_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   box_type           box_ff;
   logic [AREA_W-1:0] area_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   result_type        pend_res_ff, rsp_res_ff, done_res;

   fwd_type           fwd_chain [0:MAX_KEPT];
   verdict_type       vrd_chain [0:MAX_KEPT];

   logic              accept, csr_write, out_free, done, keep, full, wr_en;
   logic [IDX_W-1:0]  pos_eff;
   reg_index_type     csr_reg;

   assign csr_reg    = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_reg == REG_IOU_THRESHOLD) ?
                       CSR_DATA_W'(thr_ff) : '0;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign done  = vrd_chain[MAX_KEPT].done;
   assign keep  = !vrd_chain[MAX_KEPT].hit;
   assign full  = (count_ff == KEPT_FULL);
   assign wr_en = done && keep && !full;

   assign done_res.keep      = keep;
   assign done_res.overflow  = keep && full;
   assign done_res.box_index = idx_ff;

   always_comb begin
      thr_in       = thr_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      tok_in       = accept;
      busy_in      = busy_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_eff      = req_tuser ? '0 : pos_ff;

      if (csr_write && (csr_reg == REG_IOU_THRESHOLD)) begin
         thr_in = csr_pwdata[THR_W-1:0];
      end

      if (accept) begin
         busy_in  = 1'b1;
         count_in = req_tuser ? '0 : count_ff;
         idx_in   = (pos_eff > POS_LIMIT) ? POS_LIMIT : pos_eff;
         pos_in   = (pos_eff < POS_LIMIT) ? pos_eff + 1'b1 : POS_LIMIT;
      end

      if (wr_en) begin
         count_in = count_ff + 1'b1;
      end

      // pending result and a fresh one never coexist: the row is empty then
      if (out_free) begin
         rsp_valid_in = pend_ff || done;
         if (pend_ff || done) begin
            busy_in = 1'b0;
         end
         pend_in = 1'b0;
      end else if (done) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         count_ff     <= '0;
         pos_ff       <= '0;
         tok_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         tok_ff       <= tok_in;
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         box_ff.x <= req_tdata[15:0];
         box_ff.y <= req_tdata[31:16];
         box_ff.w <= req_tdata[47:32];
         box_ff.h <= req_tdata[63:48];
         area_ff  <= AREA_W'(req_tdata[47:32]) * AREA_W'(req_tdata[63:48]);
      end
      if (out_free) begin
         rsp_res_ff <= pend_ff ? pend_res_ff : done_res;
      end else if (done) begin
         pend_res_ff <= done_res;
      end
   end

   assign fwd_chain[0] = '{tok: tok_ff, box: box_ff, area: area_ff};
   assign vrd_chain[0] = '{done: 1'b0, hit: 1'b0};

   for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
      gbn_cell #(
         .CNT_W (CNT_W),
         .INDEX (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .fwd_in     (fwd_chain[k]),
         .fwd_out    (fwd_chain[k+1]),
         .vrd_in     (vrd_chain[k]),
         .vrd_out    (vrd_chain[k+1]),
         .kept_count (count_ff),
         .threshold  (thr_ff),
         .wr_en      (wr_en),
         .wr_idx     (count_ff),
         .wr_box     (box_ff),
         .wr_area    (area_ff)
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_res_ff.box_index};
   assign rsp_tuser  = {rsp_res_ff.overflow, rsp_res_ff.keep};

endmodule
